>>> design/planar_tile_decode_top_assert.svh
// assertion macros for the planar tile decoder
`ifndef PLANAR_TILE_DECODE_TOP_ASSERT_SVH
`define PLANAR_TILE_DECODE_TOP_ASSERT_SVH

`ifndef ASSERT_OFF

`define PTD_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("implication check failed");

`define PTD_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`define PTD_ASSERT_NEVER(lbl, clk, rst_n, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error("forbidden condition seen");

`else

`define PTD_ASSERT_IMPL(lbl, clk, rst_n, ante, cons)
`define PTD_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`define PTD_ASSERT_NEVER(lbl, clk, rst_n, cond)

`endif

`endif

>>> design/ptd_pkg.sv
// types and constants shared by the planar tile decoder
`default_nettype none

package ptd_pkg;

    localparam int TILE_BYTES = 256;
    localparam int MAX_WIDTH  = 16;
    localparam int MAX_HEIGHT = 16;
    localparam int MAX_DEPTH  = 8;

    localparam int BYTE_ADDR_W = $clog2(TILE_BYTES);
    localparam int BIT_POS_W   = $clog2(TILE_BYTES * 8);
    localparam int ROW_W       = $clog2(MAX_HEIGHT);
    localparam int COL_W       = $clog2(MAX_WIDTH);
    localparam int PLANE_W     = $clog2(MAX_DEPTH);

    localparam int OPCODE_W   = 3;
    localparam int INDEX_W    = 8;
    localparam int DATA_W     = 8;
    localparam int OFF_W      = 11;
    localparam int PIX_W      = 8;
    localparam int BIT_SEL_W  = 3;
    localparam int SIZE_REG_W = 5;
    localparam int DEPTH_REG_W = 4;

    localparam int PADDR_W = 4;
    localparam int PDATA_W = 32;

    typedef enum logic [OPCODE_W-1:0] {
        OP_TILE_BYTE = 3'd0,
        OP_ROW_OFF   = 3'd1,
        OP_PIX_OFF   = 3'd2,
        OP_PLANE_OFF = 3'd3,
        OP_DECODE    = 3'd4
    } opcode_t;

    localparam logic [1:0] REG_TILE_WIDTH  = 2'd0;
    localparam logic [1:0] REG_TILE_HEIGHT = 2'd1;
    localparam logic [1:0] REG_BIT_DEPTH   = 2'd2;

    localparam logic [SIZE_REG_W-1:0]  TILE_WIDTH_RST  = 5'd8;
    localparam logic [SIZE_REG_W-1:0]  TILE_HEIGHT_RST = 5'd8;
    localparam logic [DEPTH_REG_W-1:0] BIT_DEPTH_RST   = 4'd4;

    typedef struct packed {
        logic [SIZE_REG_W-1:0]  tile_width;
        logic [SIZE_REG_W-1:0]  tile_height;
        logic [DEPTH_REG_W-1:0] bit_depth;
    } cfg_t;

    typedef struct packed {
        logic                   en;
        logic [BYTE_ADDR_W-1:0] addr;
        logic [DATA_W-1:0]      data;
    } tile_wr_t;

    typedef struct packed {
        logic                                  en;
        logic [MAX_DEPTH-1:0][BYTE_ADDR_W-1:0] addr;
    } tile_rd_t;

    typedef struct packed {
        logic                                oor;
        logic [MAX_DEPTH-1:0]                plane_en;
        logic [MAX_DEPTH-1:0][BIT_SEL_W-1:0] bit_sel;
    } pix_info_t;

endpackage

`default_nettype wire

>>> design/ptd_ifs.sv
// command and pixel channel interfaces
`default_nettype none

interface ptd_cmd_if;
    logic                          valid;
    logic                          ready;
    logic [ptd_pkg::OPCODE_W-1:0]  opcode;
    logic [ptd_pkg::INDEX_W-1:0]   index;
    logic [ptd_pkg::DATA_W-1:0]    data_byte;
    logic [ptd_pkg::OFF_W-1:0]     offset_bits;
    logic [ptd_pkg::ROW_W-1:0]     row;
    logic [ptd_pkg::COL_W-1:0]     column;

    modport source (
        output valid, opcode, index, data_byte, offset_bits, row, column,
        input  ready
    );
    modport sink (
        input  valid, opcode, index, data_byte, offset_bits, row, column,
        output ready
    );
endinterface

interface ptd_pix_if;
    logic                       valid;
    logic                       ready;
    logic [ptd_pkg::PIX_W-1:0]  pixel_value;
    logic                       out_of_range;

    modport source (
        output valid, pixel_value, out_of_range,
        input  ready
    );
    modport sink (
        input  valid, pixel_value, out_of_range,
        output ready
    );
endinterface

`default_nettype wire

>>> design/ptd_cfg_regs.sv
// apb configuration registers: tile width, tile height, bit depth
`default_nettype none

module ptd_cfg_regs (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         psel,
    input  wire logic                         penable,
    input  wire logic                         pwrite,
    input  wire logic [ptd_pkg::PADDR_W-1:0]  paddr,
    input  wire logic [ptd_pkg::PDATA_W-1:0]  pwdata,
    output logic      [ptd_pkg::PDATA_W-1:0]  prdata,
    output logic                              pready,
    output ptd_pkg::cfg_t                     cfg
);

    ptd_pkg::cfg_t cfg_reg;
    logic          wr_en;
    logic [1:0]    reg_idx;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite && pready;
    assign reg_idx = paddr[3:2];
    assign cfg     = cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.tile_width  <= ptd_pkg::TILE_WIDTH_RST;
            cfg_reg.tile_height <= ptd_pkg::TILE_HEIGHT_RST;
            cfg_reg.bit_depth   <= ptd_pkg::BIT_DEPTH_RST;
        end
        else if (wr_en)
        begin
            unique case (reg_idx)
                ptd_pkg::REG_TILE_WIDTH:
                    cfg_reg.tile_width <= pwdata[ptd_pkg::SIZE_REG_W-1:0];
                ptd_pkg::REG_TILE_HEIGHT:
                    cfg_reg.tile_height <= pwdata[ptd_pkg::SIZE_REG_W-1:0];
                ptd_pkg::REG_BIT_DEPTH:
                    cfg_reg.bit_depth <= pwdata[ptd_pkg::DEPTH_REG_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    always_comb
    begin
        unique case (reg_idx)
            ptd_pkg::REG_TILE_WIDTH:  prdata = ptd_pkg::PDATA_W'(cfg_reg.tile_width);
            ptd_pkg::REG_TILE_HEIGHT: prdata = ptd_pkg::PDATA_W'(cfg_reg.tile_height);
            ptd_pkg::REG_BIT_DEPTH:   prdata = ptd_pkg::PDATA_W'(cfg_reg.bit_depth);
            default:                  prdata = '0;
        endcase
    end

endmodule

`default_nettype wire

>>> design/ptd_addr_gen.sv
// offset tables and per-plane bit position generation
`default_nettype none

module ptd_addr_gen (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           s1_valid,
    input  wire logic [ptd_pkg::OPCODE_W-1:0]   s1_opcode,
    input  wire logic [ptd_pkg::INDEX_W-1:0]    s1_index,
    input  wire logic [ptd_pkg::OFF_W-1:0]      s1_offset,
    input  wire logic [ptd_pkg::ROW_W-1:0]      s1_row,
    input  wire logic [ptd_pkg::COL_W-1:0]      s1_column,
    input  ptd_pkg::cfg_t                       cfg,
    output logic [ptd_pkg::MAX_DEPTH-1:0][ptd_pkg::BYTE_ADDR_W-1:0] byte_addr,
    output ptd_pkg::pix_info_t                  info
);

    logic [ptd_pkg::OFF_W-1:0] row_off_reg   [ptd_pkg::MAX_HEIGHT];
    logic [ptd_pkg::OFF_W-1:0] pix_off_reg   [ptd_pkg::MAX_WIDTH];
    logic [ptd_pkg::OFF_W-1:0] plane_off_reg [ptd_pkg::MAX_DEPTH];

    logic                            row_we;
    logic                            pix_we;
    logic                            plane_we;
    logic [ptd_pkg::BIT_POS_W-1:0]   base;

    assign row_we   = s1_valid && (s1_opcode == ptd_pkg::OP_ROW_OFF)
                      && (s1_index < ptd_pkg::INDEX_W'(ptd_pkg::MAX_HEIGHT));
    assign pix_we   = s1_valid && (s1_opcode == ptd_pkg::OP_PIX_OFF)
                      && (s1_index < ptd_pkg::INDEX_W'(ptd_pkg::MAX_WIDTH));
    assign plane_we = s1_valid && (s1_opcode == ptd_pkg::OP_PLANE_OFF)
                      && (s1_index < ptd_pkg::INDEX_W'(ptd_pkg::MAX_DEPTH));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < ptd_pkg::MAX_HEIGHT; i++)
            begin
                row_off_reg[i] <= '0;
            end
            for (int i = 0; i < ptd_pkg::MAX_WIDTH; i++)
            begin
                pix_off_reg[i] <= '0;
            end
            for (int i = 0; i < ptd_pkg::MAX_DEPTH; i++)
            begin
                plane_off_reg[i] <= '0;
            end
        end
        else
        begin
            if (row_we)
            begin
                row_off_reg[s1_index[ptd_pkg::ROW_W-1:0]] <= s1_offset;
            end
            if (pix_we)
            begin
                pix_off_reg[s1_index[ptd_pkg::COL_W-1:0]] <= s1_offset;
            end
            if (plane_we)
            begin
                plane_off_reg[s1_index[ptd_pkg::PLANE_W-1:0]] <= s1_offset;
            end
        end
    end

    // bit positions wrap at the tile's bit size
    assign base = ptd_pkg::BIT_POS_W'(row_off_reg[s1_row] + pix_off_reg[s1_column]);

    assign info.oor = ({1'b0, s1_row} >= cfg.tile_height)
                   || ({1'b0, s1_column} >= cfg.tile_width);

    for (genvar p = 0; p < ptd_pkg::MAX_DEPTH; p++)
    begin : g_plane
        logic [ptd_pkg::BIT_POS_W-1:0] pos;

        assign pos = ptd_pkg::BIT_POS_W'(base + plane_off_reg[p]);
        assign byte_addr[p]     = pos[ptd_pkg::BIT_POS_W-1:ptd_pkg::BIT_SEL_W];
        assign info.bit_sel[p]  = pos[ptd_pkg::BIT_SEL_W-1:0];
        assign info.plane_en[p] = ptd_pkg::DEPTH_REG_W'(p) < cfg.bit_depth;
    end

endmodule

`default_nettype wire

>>> design/ptd_tile_store.sv
// tile byte store, one copy per plane so every plane reads in the same cycle
`default_nettype none

module ptd_tile_store (
    input  wire logic                                         clk,
    input  ptd_pkg::tile_wr_t                                 wr,
    input  ptd_pkg::tile_rd_t                                 rd,
    output logic [ptd_pkg::MAX_DEPTH-1:0][ptd_pkg::DATA_W-1:0] rd_data
);

    for (genvar g = 0; g < ptd_pkg::MAX_DEPTH; g++)
    begin : g_bank
        logic [ptd_pkg::DATA_W-1:0] bank_mem [ptd_pkg::TILE_BYTES];
        logic [ptd_pkg::DATA_W-1:0] q_reg;

        always_ff @(posedge clk)
        begin
            if (wr.en)
            begin
                bank_mem[wr.addr] <= wr.data;
            end
            if (rd.en)
            begin
                q_reg <= bank_mem[rd.addr[g]];
            end
        end

        assign rd_data[g] = q_reg;
    end

endmodule

`default_nettype wire

>>> design/planar_tile_decode_top.sv
// planar tile decoder top level: input stage, tile read stage, output register
//
// usage
// - cmd channel: one beat per load or decode; opcodes 0 to 3 write a tile byte
//   or an offset table entry and give no result, opcode 4 decodes one pixel,
//   opcodes 5 to 7 are dropped
// - pix channel: one beat per decode with pixel_value and out_of_range
// - apb port: tile_width at 0x0, tile_height at 0x4, bit_depth at 0x8; write
//   only while no decode is in flight
// - a decode accepted into stage 1 moves through stage 2 to the output register, which drives pix
// - throughput: one beat per cycle while pix is not stalled; eight tile store copies give
//   every plane its own read port, so all planes are fetched in the same cycle
// - loads take effect for the very next beat
// - reset clears the offset tables and sets width 8, height 8 and depth 4;
//   tile bytes must be written before a decode reads them
// - when pix is stalled the three stages fill; cmd.ready then stays low while
//   stage 1 holds a decode, a load in stage 1 always retires
`default_nettype none

`include "planar_tile_decode_top_assert.svh"

module planar_tile_decode_top (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         psel,
    input  wire logic                         penable,
    input  wire logic                         pwrite,
    input  wire logic [ptd_pkg::PADDR_W-1:0]  paddr,
    input  wire logic [ptd_pkg::PDATA_W-1:0]  pwdata,
    output logic      [ptd_pkg::PDATA_W-1:0]  prdata,
    output logic                              pready,
    ptd_cmd_if.sink                           cmd,
    ptd_pix_if.source                         pix
);

    ptd_pkg::cfg_t cfg;

    // stage 1: accepted beat
    logic                          s1_valid_reg;
    logic [ptd_pkg::OPCODE_W-1:0]  s1_opcode_reg;
    logic [ptd_pkg::INDEX_W-1:0]   s1_index_reg;
    logic [ptd_pkg::DATA_W-1:0]    s1_data_reg;
    logic [ptd_pkg::OFF_W-1:0]     s1_offset_reg;
    logic [ptd_pkg::ROW_W-1:0]     s1_row_reg;
    logic [ptd_pkg::COL_W-1:0]     s1_column_reg;

    // stage 2: tile bytes being read
    logic                          s2_valid_reg;
    ptd_pkg::pix_info_t            s2_info_reg;

    // stage 3: output register
    logic                          out_valid_reg;
    logic [ptd_pkg::PIX_W-1:0]     out_pixel_reg;
    logic                          out_oor_reg;
    logic [ptd_pkg::PIX_W-1:0]     pixel_next;

    logic                          en3;
    logic                          en2;
    logic                          s1_decode;
    logic                          accept;

    logic [ptd_pkg::MAX_DEPTH-1:0][ptd_pkg::BYTE_ADDR_W-1:0] byte_addr;
    logic [ptd_pkg::MAX_DEPTH-1:0][ptd_pkg::DATA_W-1:0]      rd_data;
    ptd_pkg::pix_info_t            s1_info;
    ptd_pkg::tile_wr_t             tile_wr;
    ptd_pkg::tile_rd_t             tile_rd;

    ptd_cfg_regs u_cfg_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    assign en3       = !out_valid_reg || pix.ready;
    assign en2       = !s2_valid_reg || en3;
    assign s1_decode = s1_valid_reg && (s1_opcode_reg == ptd_pkg::OP_DECODE);
    // loads always retire from stage 1; decodes wait for stage 2
    assign cmd.ready = !s1_decode || en2;
    assign accept    = cmd.valid && cmd.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.ready)
            begin
                s1_valid_reg <= cmd.valid;
            end
            if (en2)
            begin
                s2_valid_reg <= s1_decode;
            end
            if (en3)
            begin
                out_valid_reg <= s2_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_opcode_reg <= cmd.opcode;
            s1_index_reg  <= cmd.index;
            s1_data_reg   <= cmd.data_byte;
            s1_offset_reg <= cmd.offset_bits;
            s1_row_reg    <= cmd.row;
            s1_column_reg <= cmd.column;
        end
        if (en2 && s1_decode)
        begin
            s2_info_reg <= s1_info;
        end
        if (en3 && s2_valid_reg)
        begin
            out_pixel_reg <= pixel_next;
            out_oor_reg   <= s2_info_reg.oor;
        end
    end

    ptd_addr_gen u_addr_gen (
        .clk       (clk),
        .rst_n     (rst_n),
        .s1_valid  (s1_valid_reg),
        .s1_opcode (s1_opcode_reg),
        .s1_index  (s1_index_reg),
        .s1_offset (s1_offset_reg),
        .s1_row    (s1_row_reg),
        .s1_column (s1_column_reg),
        .cfg       (cfg),
        .byte_addr (byte_addr),
        .info      (s1_info)
    );

    assign tile_wr.en   = s1_valid_reg && (s1_opcode_reg == ptd_pkg::OP_TILE_BYTE);
    assign tile_wr.addr = s1_index_reg[ptd_pkg::BYTE_ADDR_W-1:0];
    assign tile_wr.data = s1_data_reg;
    assign tile_rd.en   = s1_decode && en2;
    assign tile_rd.addr = byte_addr;

    ptd_tile_store u_tile_store (
        .clk     (clk),
        .wr      (tile_wr),
        .rd      (tile_rd),
        .rd_data (rd_data)
    );

    // bit 0 of a position is the msb of its byte
    always_comb
    begin
        pixel_next = '0;
        for (int p = 0; p < ptd_pkg::MAX_DEPTH; p++)
        begin
            pixel_next[p] = s2_info_reg.plane_en[p] && !s2_info_reg.oor
                && rd_data[p][ptd_pkg::BIT_SEL_W'(ptd_pkg::DATA_W - 1)
                              - s2_info_reg.bit_sel[p]];
        end
    end

    assign pix.valid        = out_valid_reg;
    assign pix.pixel_value  = out_pixel_reg;
    assign pix.out_of_range = out_oor_reg;

    `PTD_ASSERT_IMPL(a_oor_pixel_zero, clk, rst_n, pix.valid && pix.out_of_range, pix.pixel_value == '0)
    `PTD_ASSERT_IMPL(a_depth_mask, clk, rst_n, pix.valid, (pix.pixel_value >> cfg.bit_depth) == '0)
    `PTD_ASSERT_NEVER(a_no_rw_clash, clk, rst_n, tile_wr.en && tile_rd.en)
    `PTD_ASSERT_NEXT(a_read_fills_s2, clk, rst_n, tile_rd.en, s2_valid_reg)

endmodule

`default_nettype wire

>>> dv/planar_tile_decode_top_tb.sv
`timescale 1ns / 1ps
// self-checking testbench for the planar tile decoder with a pixel predictor
module planar_tile_decode_top_tb;

    localparam logic [ptd_pkg::OPCODE_W-1:0] OP_RSVD_FIRST = 3'd5;
    localparam logic [ptd_pkg::OPCODE_W-1:0] OP_RSVD_LAST  = 3'd7;
    localparam int TILE_BITS     = ptd_pkg::TILE_BYTES * 8;
    localparam int SETTLE_CYCLES = 4;
    localparam int IDLE_LIMIT    = 4000;
    localparam int PHASE_BEATS   = 90;
    localparam int NUM_PHASES    = 8;

    typedef struct {
        logic [ptd_pkg::OPCODE_W-1:0] opcode;
        logic [ptd_pkg::INDEX_W-1:0]  index;
        logic [ptd_pkg::DATA_W-1:0]   data_byte;
        logic [ptd_pkg::OFF_W-1:0]    offset_bits;
        logic [ptd_pkg::ROW_W-1:0]    row;
        logic [ptd_pkg::COL_W-1:0]    column;
    } cmd_beat_t;

    typedef struct {
        logic [ptd_pkg::PIX_W-1:0] pixel_value;
        logic                      out_of_range;
    } pixel_t;

    logic                         clk = 1'b0;
    logic                         rst_n;
    logic                         psel;
    logic                         penable;
    logic                         pwrite;
    logic [ptd_pkg::PADDR_W-1:0]  paddr;
    logic [ptd_pkg::PDATA_W-1:0]  pwdata;
    logic [ptd_pkg::PDATA_W-1:0]  prdata;
    logic                         pready;

    ptd_cmd_if cmd_if();
    ptd_pix_if pix_if();

    planar_tile_decode_top u_dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cmd     (cmd_if),
        .pix     (pix_if)
    );

    always #2 clk = ~clk;

    // predictor state
    logic [ptd_pkg::DATA_W-1:0]      tile_mem  [ptd_pkg::TILE_BYTES];
    logic [ptd_pkg::OFF_W-1:0]       row_off   [ptd_pkg::MAX_HEIGHT];
    logic [ptd_pkg::OFF_W-1:0]       pix_off   [ptd_pkg::MAX_WIDTH];
    logic [ptd_pkg::OFF_W-1:0]       plane_off [ptd_pkg::MAX_DEPTH];
    logic [ptd_pkg::SIZE_REG_W-1:0]  cfg_width;
    logic [ptd_pkg::SIZE_REG_W-1:0]  cfg_height;
    logic [ptd_pkg::DEPTH_REG_W-1:0] cfg_depth;

    cmd_beat_t cmd_pending_q[$];
    pixel_t    pixel_expected_q[$];

    int beats_queued;
    int beats_accepted;
    int pixels_checked;
    int oor_predicted;
    int reg_writes;
    int mismatch_count;
    int idle_cycles;
    int cmd_gap_left;
    int cmd_calm;
    int pix_stall_left;
    int pix_calm;

    int phase_width [NUM_PHASES] = '{16, 1, 0, 31, 17, 5, 12, 16};
    int phase_height[NUM_PHASES] = '{16, 1, 5, 31, 3, 0, 16, 10};
    int phase_depth [NUM_PHASES] = '{8, 1, 3, 15, 0, 9, 8, 6};

    cmd_beat_t seen_beat;
    pixel_t    want_pixel;

    task automatic note_mismatch(string what);
        $display("mismatch at %0t: %s", $time, what);
        mismatch_count++;
    endtask

    function automatic int clamp_to(int v, int top);
        return (v > top) ? top : v;
    endfunction

    function automatic pixel_t decode_pixel(int r, int c);
        pixel_t px;
        int w;
        int h;
        int d;
        int base;
        int pos;
        int p;
        logic [ptd_pkg::DATA_W-1:0] b;
        w = clamp_to(int'(cfg_width), ptd_pkg::MAX_WIDTH);
        h = clamp_to(int'(cfg_height), ptd_pkg::MAX_HEIGHT);
        d = clamp_to(int'(cfg_depth), ptd_pkg::MAX_DEPTH);
        px.pixel_value = '0;
        px.out_of_range = 1'b0;
        if (r >= h || c >= w)
        begin
            px.out_of_range = 1'b1;
            return px;
        end
        base = int'(row_off[r]) + int'(pix_off[c]);
        for (p = 0; p < d; p++)
        begin
            pos = (base + int'(plane_off[p])) % TILE_BITS;
            b = tile_mem[pos / ptd_pkg::DATA_W];
            // msb-first within the byte
            px.pixel_value[p] = b[(ptd_pkg::DATA_W - 1) - (pos % ptd_pkg::DATA_W)];
        end
        return px;
    endfunction

    function automatic void apply_cmd_beat(cmd_beat_t b);
        pixel_t px;
        case (b.opcode)
            ptd_pkg::OP_TILE_BYTE:
                tile_mem[int'(b.index) % ptd_pkg::TILE_BYTES] = b.data_byte;
            ptd_pkg::OP_ROW_OFF:
                if (int'(b.index) < ptd_pkg::MAX_HEIGHT) row_off[b.index] = b.offset_bits;
            ptd_pkg::OP_PIX_OFF:
                if (int'(b.index) < ptd_pkg::MAX_WIDTH) pix_off[b.index] = b.offset_bits;
            ptd_pkg::OP_PLANE_OFF:
                if (int'(b.index) < ptd_pkg::MAX_DEPTH) plane_off[b.index] = b.offset_bits;
            ptd_pkg::OP_DECODE:
            begin
                px = decode_pixel(int'(b.row), int'(b.column));
                pixel_expected_q.push_back(px);
                if (px.out_of_range)
                    oor_predicted++;
            end
            default: ;
        endcase
    endfunction

    function automatic int pick_gap(inout int calm);
        int r;
        if (calm > 0)
        begin
            calm--;
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 3)
        begin
            calm = $urandom_range(20, 80);
            return 0;
        end
        if (r < 60)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        if (r < 98)
            return $urandom_range(4, 12);
        return $urandom_range(20, 40);
    endfunction

    function automatic cmd_beat_t mk_beat(logic [ptd_pkg::OPCODE_W-1:0] op, int idx,
                                          int data, int off, int r, int c);
        cmd_beat_t b;
        b.opcode      = op;
        b.index       = ptd_pkg::INDEX_W'(idx);
        b.data_byte   = ptd_pkg::DATA_W'(data);
        b.offset_bits = ptd_pkg::OFF_W'(off);
        b.row         = ptd_pkg::ROW_W'(r);
        b.column      = ptd_pkg::COL_W'(c);
        return b;
    endfunction

    function automatic cmd_beat_t random_beat();
        cmd_beat_t b;
        int r;
        int w;
        int h;
        b = mk_beat(ptd_pkg::OP_DECODE, $urandom_range(0, 255), $urandom_range(0, 255),
                    $urandom_range(0, 2047), $urandom_range(0, 15), $urandom_range(0, 15));
        w = clamp_to(int'(cfg_width), ptd_pkg::MAX_WIDTH);
        h = clamp_to(int'(cfg_height), ptd_pkg::MAX_HEIGHT);
        r = $urandom_range(0, 99);
        if (r < 45)
        begin
            // mostly in-range pixels so the bit gather gets exercised
            if (w > 0 && h > 0 && $urandom_range(0, 3) != 0)
            begin
                b.row    = ptd_pkg::ROW_W'($urandom_range(0, h - 1));
                b.column = ptd_pkg::COL_W'($urandom_range(0, w - 1));
            end
        end
        else if (r < 63)
            b.opcode = ptd_pkg::OP_TILE_BYTE;
        else if (r < 73)
        begin
            b.opcode = ptd_pkg::OP_ROW_OFF;
            if ($urandom_range(0, 7) != 0)
                b.index = ptd_pkg::INDEX_W'($urandom_range(0, ptd_pkg::MAX_HEIGHT - 1));
        end
        else if (r < 83)
        begin
            b.opcode = ptd_pkg::OP_PIX_OFF;
            if ($urandom_range(0, 7) != 0)
                b.index = ptd_pkg::INDEX_W'($urandom_range(0, ptd_pkg::MAX_WIDTH - 1));
        end
        else if (r < 94)
        begin
            b.opcode = ptd_pkg::OP_PLANE_OFF;
            if ($urandom_range(0, 7) != 0)
                b.index = ptd_pkg::INDEX_W'($urandom_range(0, ptd_pkg::MAX_DEPTH - 1));
        end
        else
            b.opcode = ptd_pkg::OPCODE_W'($urandom_range(OP_RSVD_FIRST, OP_RSVD_LAST));
        return b;
    endfunction

    task automatic queue_beat(cmd_beat_t b);
        cmd_pending_q.push_back(b);
        beats_queued++;
    endtask

    task automatic wait_drained();
        while (beats_accepted != beats_queued || pixel_expected_q.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(logic [1:0] idx, int value);
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= ptd_pkg::PDATA_W'(value);
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            ptd_pkg::REG_TILE_WIDTH:  cfg_width  = ptd_pkg::SIZE_REG_W'(value);
            ptd_pkg::REG_TILE_HEIGHT: cfg_height = ptd_pkg::SIZE_REG_W'(value);
            ptd_pkg::REG_BIT_DEPTH:   cfg_depth  = ptd_pkg::DEPTH_REG_W'(value);
            default: ;
        endcase
        reg_writes++;
    endtask

    // command driver
    always @(posedge clk)
    begin
        if (rst_n && (!cmd_if.valid || cmd_if.ready))
        begin
            if (cmd_gap_left > 0)
            begin
                cmd_gap_left--;
                cmd_if.valid <= 1'b0;
            end
            else if (cmd_pending_q.size() != 0)
            begin
                seen_beat = cmd_pending_q.pop_front();
                cmd_if.opcode      <= seen_beat.opcode;
                cmd_if.index       <= seen_beat.index;
                cmd_if.data_byte   <= seen_beat.data_byte;
                cmd_if.offset_bits <= seen_beat.offset_bits;
                cmd_if.row         <= seen_beat.row;
                cmd_if.column      <= seen_beat.column;
                cmd_if.valid       <= 1'b1;
                cmd_gap_left = pick_gap(cmd_calm);
            end
            else
                cmd_if.valid <= 1'b0;
        end
    end

    // pixel sink backpressure
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (pix_stall_left == 0)
                pix_stall_left = pick_gap(pix_calm);
            if (pix_stall_left > 0)
            begin
                pix_stall_left--;
                pix_if.ready <= 1'b0;
            end
            else
                pix_if.ready <= 1'b1;
        end
    end

    // command beat monitor feeds the predictor
    always @(posedge clk)
    begin
        if (rst_n && cmd_if.valid && cmd_if.ready)
        begin
            apply_cmd_beat(mk_beat(cmd_if.opcode, int'(cmd_if.index), int'(cmd_if.data_byte),
                                   int'(cmd_if.offset_bits), int'(cmd_if.row),
                                   int'(cmd_if.column)));
            beats_accepted++;
        end
    end

    // pixel beat monitor
    always @(posedge clk)
    begin
        if (rst_n && pix_if.valid && pix_if.ready)
        begin
            if (pixel_expected_q.size() == 0)
                note_mismatch("pixel beat with nothing pending");
            else
            begin
                want_pixel = pixel_expected_q.pop_front();
                pixels_checked++;
                if (pix_if.pixel_value !== want_pixel.pixel_value)
                    note_mismatch($sformatf("pixel_value got %h want %h",
                                            pix_if.pixel_value, want_pixel.pixel_value));
                if (pix_if.out_of_range !== want_pixel.out_of_range)
                    note_mismatch($sformatf("out_of_range got %b want %b",
                                            pix_if.out_of_range, want_pixel.out_of_range));
            end
        end
    end

    // watchdog on cycles without any beat or register access
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((cmd_if.valid && cmd_if.ready) || (pix_if.valid && pix_if.ready) ||
                (psel && penable && pready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("timeout after %0d idle cycles", idle_cycles);
                $display("planar_tile_decode_top_tb failed");
                $finish;
            end
        end
    end

    initial
    begin
        rst_n = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        cmd_if.valid = 1'b0;
        cmd_if.opcode = ptd_pkg::OP_TILE_BYTE;
        cmd_if.index = '0;
        cmd_if.data_byte = '0;
        cmd_if.offset_bits = '0;
        cmd_if.row = '0;
        cmd_if.column = '0;
        pix_if.ready = 1'b0;
        foreach (tile_mem[i]) tile_mem[i] = '0;
        foreach (row_off[i]) row_off[i] = '0;
        foreach (pix_off[i]) pix_off[i] = '0;
        foreach (plane_off[i]) plane_off[i] = '0;
        cfg_width = ptd_pkg::TILE_WIDTH_RST;
        cfg_height = ptd_pkg::TILE_HEIGHT_RST;
        cfg_depth = ptd_pkg::BIT_DEPTH_RST;

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        // out of range decodes and a dropped opcode touch no tile byte
        queue_beat(mk_beat(ptd_pkg::OP_DECODE, 0, 0, 0, 15, 0));
        queue_beat(mk_beat(ptd_pkg::OP_DECODE, 0, 0, 0, 0, 8));
        queue_beat(mk_beat(OP_RSVD_LAST, 255, 255, 2047, 15, 15));

        // fill the tile store before anything reads it
        for (int i = 0; i < ptd_pkg::TILE_BYTES; i++)
            queue_beat(mk_beat(ptd_pkg::OP_TILE_BYTE, i, $urandom_range(0, 255), 0, 0, 0));

        queue_beat(mk_beat(ptd_pkg::OP_DECODE, 0, 0, 0, 0, 0));
        queue_beat(mk_beat(ptd_pkg::OP_PLANE_OFF, 1, 0, 1, 0, 0));
        queue_beat(mk_beat(ptd_pkg::OP_PLANE_OFF, 2, 0, 2047, 0, 0));
        queue_beat(mk_beat(ptd_pkg::OP_PLANE_OFF, 3, 0, 1024, 0, 0));
        queue_beat(mk_beat(ptd_pkg::OP_DECODE, 0, 0, 0, 0, 0));
        queue_beat(mk_beat(ptd_pkg::OP_ROW_OFF, 7, 0, 2047, 0, 0));
        queue_beat(mk_beat(ptd_pkg::OP_PIX_OFF, 7, 0, 2040, 0, 0));
        queue_beat(mk_beat(ptd_pkg::OP_DECODE, 0, 0, 0, 7, 7));
        queue_beat(mk_beat(ptd_pkg::OP_ROW_OFF, 15, 0, 5, 0, 0));
        queue_beat(mk_beat(ptd_pkg::OP_PIX_OFF, 15, 0, 7, 0, 0));
        queue_beat(mk_beat(ptd_pkg::OP_DECODE, 0, 0, 0, 8, 0));
        queue_beat(mk_beat(ptd_pkg::OP_DECODE, 0, 0, 0, 0, 8));
        queue_beat(mk_beat(ptd_pkg::OP_DECODE, 0, 0, 0, 15, 15));
        // table indexes past the table depth
        queue_beat(mk_beat(ptd_pkg::OP_ROW_OFF, 16, 0, 3, 0, 0));
        queue_beat(mk_beat(ptd_pkg::OP_PIX_OFF, 255, 0, 3, 0, 0));
        queue_beat(mk_beat(ptd_pkg::OP_PLANE_OFF, 8, 0, 3, 0, 0));
        queue_beat(mk_beat(ptd_pkg::OP_DECODE, 0, 0, 0, 0, 0));
        queue_beat(mk_beat(ptd_pkg::OP_TILE_BYTE, 0, 255, 0, 0, 0));
        queue_beat(mk_beat(ptd_pkg::OP_TILE_BYTE, 255, 0, 0, 0, 0));
        queue_beat(mk_beat(ptd_pkg::OP_DECODE, 0, 0, 0, 0, 0));
        queue_beat(mk_beat(OP_RSVD_FIRST, 0, 0, 0, 0, 0));
        queue_beat(mk_beat(ptd_pkg::OP_DECODE, 0, 0, 0, 7, 7));

        for (int i = 0; i < PHASE_BEATS; i++)
            queue_beat(random_beat());

        for (int ph = 0; ph < NUM_PHASES; ph++)
        begin
            // hold the sender until every pixel is back, then retune sizes
            wait_drained();
            write_reg(ptd_pkg::REG_TILE_WIDTH, phase_width[ph]);
            write_reg(ptd_pkg::REG_TILE_HEIGHT, phase_height[ph]);
            write_reg(ptd_pkg::REG_BIT_DEPTH, phase_depth[ph]);
            for (int i = 0; i < PHASE_BEATS; i++)
                queue_beat(random_beat());
        end

        wait_drained();
        $display("sent %0d command beats over %0d size settings (%0d register writes)",
                 beats_accepted, NUM_PHASES + 1, reg_writes);
        $display("checked %0d pixels, %0d of them out of range, %0d mismatches",
                 pixels_checked, oor_predicted, mismatch_count);
        if (mismatch_count == 0)
            $display("planar_tile_decode_top_tb passed");
        else
            $display("planar_tile_decode_top_tb failed");
        $finish;
    end

endmodule
